### src/fpi4_pkg.sv
// shared types and constants for the first public ipv4 header scanner
// no dependencies
`timescale 1ns / 1ps

package fpi4_pkg;

	// character codes
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam int unsigned NUM_RANGES = 8;
	localparam logic [8:0] OCTET_MAX = 9'd255;
	localparam logic [2:0] LAST_OCTET = 3'd3;
	localparam logic [1:0] DIGITS_MAX = 2'd3;

	// reserved ranges, bounds inclusive
	localparam logic [31:0] RANGE_LO [NUM_RANGES] = '{
		32'd167772160, 32'd1681915904, 32'd2130706432, 32'd2886729728,
		32'd3221225984, 32'd3227017984, 32'd3232235520, 32'd2851995648
	};
	localparam logic [31:0] RANGE_HI [NUM_RANGES] = '{
		32'd184549375, 32'd1686110207, 32'd2147483647, 32'd2887778303,
		32'd3221226239, 32'd3227018239, 32'd3232301055, 32'd2852061183
	};

	// per-token parse state
	typedef struct packed {
		logic [8:0]  octet_value;
		logic [2:0]  octet_index;
		logic [1:0]  digit_count;
		logic        token_active;
		logic        token_invalid;
		logic [23:0] partial_address;
	} parse_state_t;

	// token close event from parser to top level
	typedef struct packed {
		logic        close;
		logic        token_ok;
		logic [31:0] address;
	} token_evt_t;

endpackage

### src/fpi4_range_check.sv
// reserved ipv4 range compare, eight ranges in parallel
// depends on fpi4_pkg
`timescale 1ns / 1ps

module fpi4_range_check (
	input  logic [31:0] address,
	output logic        reserved
);

	logic [fpi4_pkg::NUM_RANGES-1:0] hit;

	always_comb begin
		for (int i = 0; i < fpi4_pkg::NUM_RANGES; i++) begin
			hit[i] = (address >= fpi4_pkg::RANGE_LO[i]) && (address <= fpi4_pkg::RANGE_HI[i]);
		end
	end

	assign reserved = |hit;

endmodule

### src/fpi4_token_parser.sv
// dotted-quad token parser, one header byte per step
// depends on fpi4_pkg
`timescale 1ns / 1ps

module fpi4_token_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            header_byte,
	input  logic                  last_byte,
	output fpi4_pkg::token_evt_t  evt
);

	fpi4_pkg::parse_state_t state_q;
	fpi4_pkg::parse_state_t state_nxt;
	logic        sep;
	logic        is_digit;
	logic [11:0] times_ten;

	assign sep = (header_byte == fpi4_pkg::CHAR_SPACE) || (header_byte == fpi4_pkg::CHAR_TAB)
		|| (header_byte == fpi4_pkg::CHAR_COMMA);
	assign is_digit = (header_byte >= fpi4_pkg::CHAR_ZERO) && (header_byte <= fpi4_pkg::CHAR_NINE);
	assign times_ten = {state_q.octet_value, 3'b000} + {2'b00, state_q.octet_value, 1'b0}
		+ {8'd0, header_byte[3:0]};

	always_comb begin
		state_nxt = state_q;
		if (!sep) begin
			state_nxt.token_active = 1'b1;
			if (!state_q.token_invalid) begin
				if (is_digit) begin
					if (state_q.digit_count == 2'd0) begin
						state_nxt.octet_value = {5'd0, header_byte[3:0]};
						state_nxt.digit_count = 2'd1;
					end else if (state_q.octet_value == 9'd0) begin
						// leading zero
						state_nxt.token_invalid = 1'b1;
					end else if (times_ten > {3'd0, fpi4_pkg::OCTET_MAX}) begin
						state_nxt.token_invalid = 1'b1;
					end else begin
						state_nxt.octet_value = times_ten[8:0];
						if (state_q.digit_count < fpi4_pkg::DIGITS_MAX) begin
							state_nxt.digit_count = state_q.digit_count + 2'd1;
						end
					end
				end else if (header_byte == fpi4_pkg::CHAR_DOT) begin
					if (state_q.digit_count == 2'd0 || state_q.octet_index >= fpi4_pkg::LAST_OCTET) begin
						state_nxt.token_invalid = 1'b1;
					end else begin
						state_nxt.partial_address = {state_q.partial_address[15:0],
							state_q.octet_value[7:0]};
						state_nxt.octet_index = state_q.octet_index + 3'd1;
						state_nxt.digit_count = 2'd0;
						state_nxt.octet_value = 9'd0;
					end
				end else begin
					state_nxt.token_invalid = 1'b1;
				end
			end
		end
	end

	// token judged on the updated state
	always_comb begin
		evt.close    = sep || last_byte;
		evt.token_ok = state_nxt.token_active && !state_nxt.token_invalid
			&& (state_nxt.octet_index == fpi4_pkg::LAST_OCTET) && (state_nxt.digit_count != 2'd0);
		evt.address  = {state_nxt.partial_address, state_nxt.octet_value[7:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			if (evt.close) begin
				state_q <= '0;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

endmodule

### src/first_public_ipv4_from_forward_list_core.sv
// top level of the first public ipv4 header scanner
// depends on fpi4_pkg, fpi4_token_parser, fpi4_range_check
`timescale 1ns / 1ps

// usage
// - input channel (in_valid / in_stall) carries one header byte per request
//   with last_byte high on the final byte of a header
// - output channel (out_valid / out_stall) carries one request per header:
//   address_found and client_address (zero when nothing was found)
// - a byte is captured in an input register, then parsed from that register
//   by short logic: digit update, dot handling and eight parallel range
//   compares; the first public address is kept in match registers
// - throughput: one byte per cycle, set by the single parse stage, except
//   while a final byte waits for the output register to be free; the result
//   is loaded into the output register when the final byte leaves the input register
// - the input register keeps accepting bytes while a result waits on a
//   stalled output; only a second final byte waits until the output
//   register is taken, and then in_stall goes high
// - reset clears the parse state, the kept match and both valid flags
// - without a final byte no result is ever given

module first_public_ipv4_from_forward_list_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  header_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        address_found,
	output logic [31:0] client_address
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// kept match
	logic        match_seen_q;
	logic [31:0] match_address_q;

	// output register
	logic        out_valid_q;
	logic        found_q;
	logic [31:0] address_q;

	fpi4_pkg::token_evt_t evt;
	logic reserved;
	logic out_free;
	logic advance;
	logic take_match;
	logic seen_nxt;
	logic [31:0] addr_nxt;

	fpi4_token_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.header_byte (byte_s1),
		.last_byte   (last_s1),
		.evt         (evt)
	);

	fpi4_range_check u_range (
		.address  (evt.address),
		.reserved (reserved)
	);

	// output slot free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	// a non-final byte never needs the output slot
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !advance;

	assign take_match = evt.close && evt.token_ok && !match_seen_q && !reserved;
	assign seen_nxt   = match_seen_q || take_match;
	assign addr_nxt   = take_match ? evt.address : match_address_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= header_byte;
			last_s1 <= last_byte;
		end
	end

	// match registers, cleared at the end of each header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_seen_q    <= 1'b0;
			match_address_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				match_seen_q    <= 1'b0;
				match_address_q <= '0;
			end else begin
				match_seen_q    <= seen_nxt;
				match_address_q <= addr_nxt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			found_q   <= seen_nxt;
			address_q <= seen_nxt ? addr_nxt : 32'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign address_found  = found_q;
	assign client_address = address_q;

endmodule
